// ===== hw/rtl/isr_pkg.sv =====
// shared types and constants for the integer square root block
`default_nettype none
package isr_pkg;

    localparam int ISR_VALUE_BITS = 31;
    localparam int ROOT_BITS      = 16;
    localparam int MUL_MAX_BITS   = 32;

    typedef enum logic [1:0] {
        EMIT_VALUE = 2'd0,
        EMIT_HI    = 2'd1,
        EMIT_MID   = 2'd2
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      calc_mid;
        logic      square;
        logic      narrow_hi;
        logic      narrow_lo;
        logic      emit;
        emit_sel_t emit_sel;
    } isr_cmd_t;

    typedef struct packed {
        logic trivial;
        logic range_empty;
        logic above;
        logic equal;
    } isr_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/isr_value_if.sv =====
// request channel carrying the value to be rooted
`default_nettype none
interface isr_value_if #(
    parameter int VALUE_BITS = isr_pkg::ISR_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isr_root_if.sv =====
// result channel carrying the floor square root
`default_nettype none
interface isr_root_if;
    logic                          valid;
    logic                          ready;
    logic [isr_pkg::ROOT_BITS-1:0] root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isr_datapath.sv =====
// search bounds, midpoint squarer and compare for the square root search
`default_nettype none
module isr_datapath #(
    parameter int VALUE_BITS = isr_pkg::ISR_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire isr_pkg::isr_cmd_t             cmd,
    input  wire logic [VALUE_BITS-1:0]         value,
    output isr_pkg::isr_status_t               status,
    output logic [isr_pkg::ROOT_BITS-1:0]      root
);
    import isr_pkg::*;

    localparam int W         = VALUE_BITS + 1;
    localparam int MUL_BITS  = (W < MUL_MAX_BITS) ? W : MUL_MAX_BITS;
    localparam int PROD_BITS = 2 * MUL_BITS;

    logic [VALUE_BITS-1:0] v_reg;
    logic [W-1:0]          lo_reg, hi_reg, mid_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  big_reg;
    logic [ROOT_BITS-1:0]  root_reg;

    logic [W-1:0]          mid_next;
    logic [W-1:0]          mid_upper;
    logic [W-1:0]          emit_src;
    logic [ROOT_BITS+W-1:0] emit_ext;
    logic [PROD_BITS-1:0]  v_ext;

    assign mid_next  = lo_reg + ((hi_reg - lo_reg) >> 1);
    // midpoints of 2^32 and up are treated as too large without squaring
    assign mid_upper = mid_reg >> MUL_BITS;
    assign v_ext     = PROD_BITS'(v_reg);

    always_comb
    begin
        case (cmd.emit_sel)
            EMIT_VALUE: emit_src = {1'b0, v_reg};
            EMIT_HI:    emit_src = hi_reg;
            EMIT_MID:   emit_src = mid_reg;
            default:    emit_src = hi_reg;
        endcase
        emit_ext = {{ROOT_BITS{1'b0}}, emit_src};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg  <= value;
            lo_reg <= W'(1);
            hi_reg <= {1'b0, value};
        end
        if (cmd.calc_mid)
            mid_reg <= mid_next;
        if (cmd.square)
        begin
            prod_reg <= PROD_BITS'(mid_reg[MUL_BITS-1:0]) * PROD_BITS'(mid_reg[MUL_BITS-1:0]);
            big_reg  <= |mid_upper;
        end
        if (cmd.narrow_hi)
            hi_reg <= mid_reg - W'(1);
        if (cmd.narrow_lo)
            lo_reg <= mid_reg + W'(1);
        if (cmd.emit)
            root_reg <= emit_ext[ROOT_BITS-1:0];
    end

    assign status.trivial     = (v_reg[VALUE_BITS-1:1] == '0);
    assign status.range_empty = (lo_reg > hi_reg);
    assign status.above       = big_reg || (prod_reg > v_ext);
    assign status.equal       = !big_reg && (prod_reg == v_ext);
    assign root               = root_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/isr_ctrl.sv =====
// sequencer for the binary search and the result register handshake
`default_nettype none
module isr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    input  wire isr_pkg::isr_status_t status,
    output isr_pkg::isr_cmd_t         cmd
);
    import isr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MID  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_CMP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // result slot can take a new root this cycle
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = EMIT_HI;
        req_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                if (status.trivial)
                begin
                    cmd.emit_sel = EMIT_VALUE;
                    if (out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (status.range_empty)
                begin
                    if (out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.calc_mid = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.square = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.above)
                begin
                    cmd.narrow_hi = 1'b1;
                    state_next    = ST_MID;
                end
                else if (status.equal)
                begin
                    cmd.emit_sel = EMIT_MID;
                    if (out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.narrow_lo = 1'b1;
                    state_next    = ST_MID;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (cmd.emit)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/integer_square_root.sv =====
// Integer square root: one request of VALUE_BITS bits in, one 16-bit floor
// root out. The root is found by a binary search over 1 .. value; each probe
// steps through midpoint, 32x32 square and compare, limited by the single
// shared squarer. A request takes a load step, at most about VALUE_BITS
// probes and a closing step that waits for a free result slot; values 0 and
// 1 skip the search. Only one request is in flight, but a finished root waits
// in its output register while the next request is searched. Bits of value
// above VALUE_BITS are not used.
`default_nettype none
module integer_square_root #(
    parameter int VALUE_BITS = isr_pkg::ISR_VALUE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    isr_value_if.sink  req,
    isr_root_if.source rsp
);
    import isr_pkg::*;

    isr_cmd_t    cmd;
    isr_status_t status;

    isr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    isr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk    (clk),
        .cmd    (cmd),
        .value  (req.value[VALUE_BITS-1:0]),
        .status (status),
        .root   (rsp.root)
    );

    // a root is only written into a free result slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp.valid || rsp.ready))
        else $error("root written over a pending result");

    // at most one datapath operation per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc_mid, cmd.square, cmd.narrow_hi, cmd.narrow_lo,
                  cmd.emit}))
        else $error("conflicting datapath commands");

    // an emitted root shows up as a valid result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp.valid)
        else $error("emitted root not presented");

    // a new request is never taken while the search is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.calc_mid || cmd.square || cmd.narrow_hi || cmd.narrow_lo) |-> !req.ready)
        else $error("request accepted during search");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for integer_square_root with a root scoreboard and random stalls
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import isr_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 427;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [63:0] MID_CEILING = 64'hFFFF_FFFF;

    typedef logic [ISR_VALUE_BITS-1:0] value_t;
    typedef logic [ROOT_BITS-1:0]      root_t;

    class root_tracker;
        root_t pending_roots[$];
        int    mismatches;
        int    values_noted;

        function new();
            mismatches   = 0;
            values_noted = 0;
        endfunction

        // binary search over 1 .. v, squares taken at full width
        function root_t floor_sqrt(value_t v);
            logic [63:0] x;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            logic [63:0] sq;
            x = 64'(v);
            if (x <= 64'd1)
                return root_t'(x);
            lo = 64'd1;
            hi = x;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 64'd2;
                if (mid > MID_CEILING)
                begin
                    hi = mid - 64'd1;
                    continue;
                end
                sq = mid * mid;
                if (sq > x)
                    hi = mid - 64'd1;
                else if (sq == x)
                    return root_t'(mid);
                else
                    lo = mid + 64'd1;
            end
            return root_t'(hi);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        function void note_value(value_t v);
            pending_roots = {pending_roots, floor_sqrt(v)};
            values_noted++;
        endfunction

        task check_root(root_t got);
            root_t want;
            if (pending_roots.size() == 0)
            begin
                report_mismatch($sformatf("root %0d arrived with no request outstanding", got));
                return;
            end
            want = pending_roots.pop_front();
            if (got !== want)
                report_mismatch($sformatf("root %0d, expected %0d", got, want));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic hold_off;
    int   phase;
    int   cycle_count;

    int source_idle_pct[3] = '{36, 69, 0};
    int sink_idle_pct[3]   = '{69, 36, 0};

    root_tracker store;
    value_t      stimulus[$];

    isr_value_if req_ch ();
    isr_root_if  rsp_ch ();

    integer_square_root i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic value_t random_value();
        int    pick;
        int    k;
        value_t sqv;
        pick = $urandom_range(99);
        k    = $urandom_range(46340);
        sqv  = value_t'(k * k);
        if (pick < 40)
            return sqv;
        else if (pick < 52)
            return (k > 0) ? sqv - 1'b1 : sqv;
        else if (pick < 65)
            return sqv + 1'b1;
        else if (pick < 90)
            return value_t'($urandom());
        else
            return value_t'($urandom_range(300));
    endfunction

    task automatic build_stimulus();
        value_t all_ones;
        all_ones = '1;
        stimulus = '{0, 1, 2, 3, 4, 5, 8, 9, 15, 16, 17, 99, 100, 65535, 65536};
        // largest perfect square in range and its neighbors
        stimulus = {stimulus, value_t'(46340 * 46340)};
        stimulus = {stimulus, value_t'(46340 * 46340 - 1)};
        stimulus = {stimulus, value_t'(46340 * 46340 + 1)};
        stimulus = {stimulus, all_ones};
        stimulus = {stimulus, all_ones - 1'b1};
        stimulus = {stimulus, value_t'(1) << (ISR_VALUE_BITS - 1)};
        stimulus = {stimulus, value_t'(31'h2AAA_AAAA)};
        stimulus = {stimulus, value_t'(31'h5555_5555)};
        for (int i = 0; i < RANDOM_ITEMS; i++)
            stimulus = {stimulus, random_value()};
    endtask

    task automatic drive_requests();
        int idle;
        for (int i = 0; i < stimulus.size(); i++)
        begin
            phase <= (i * 3) / stimulus.size();
            idle = 0;
            while ($urandom_range(99) < source_idle_pct[(i * 3) / stimulus.size()])
                idle++;
            if (idle > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.value <= stimulus[i];
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            store.note_value(stimulus[i]);
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                store.check_root(rsp_ch.root);
            rsp_ch.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct[phase]);
        end
    end

    // long receiver stalls so the block backs up into its request side
    initial
    begin
        hold_off <= 1'b0;
        @(posedge clk);
        while (store == null || store.values_noted < 20)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        while (store.values_noted < 380)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        store = new();
        phase <= 0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.value <= '0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_requests();
        while (store.pending_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (store.pending_roots.size() != 0)
            store.report_mismatch($sformatf("%0d roots never arrived",
                                            store.pending_roots.size()));
        if (store.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/isr_pkg.sv
hw/rtl/isr_value_if.sv
hw/rtl/isr_root_if.sv
hw/rtl/isr_datapath.sv
hw/rtl/isr_ctrl.sv
hw/rtl/integer_square_root.sv
tb/testbench.sv
